// ===== sv/vertical_accel_integrator_zupt_core_assert.svh =====
// ----------------------------------------------------------------------------
// vertical accel integrator assertion macros
// shared assertion forms, clocked on clk_i and off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef VERTICAL_ACCEL_INTEGRATOR_ZUPT_CORE_ASSERT_SVH
`define VERTICAL_ACCEL_INTEGRATOR_ZUPT_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define VAIZ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define VAIZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vaiz_pkg.sv =====
// ----------------------------------------------------------------------------
// vaiz_pkg
// widths, constants and inter-module types of the vertical accel integrator
// ----------------------------------------------------------------------------
package vaiz_pkg;

  localparam int ACCEL_W = 20;
  localparam int DT_W    = 16;
  localparam int BAND_W  = 16;
  localparam int DRIFT_W = 26;
  localparam int CORR_W  = 24;
  localparam int VEL_W   = 32;
  localparam int DIST_W  = 48;

  localparam int ERRG_W = ACCEL_W + 1;
  localparam int GRAV_W = 20;
  localparam logic [GRAV_W-1:0] GRAV_Q16  = 20'd642689;
  localparam logic [ERRG_W-1:0] ONE_G_Q16 = 21'd65536;
  localparam int FRAC_G  = 16;
  localparam int FRAC_DT = 20;

  // shift-add multiplier: signed multiplicand, unsigned multiplier
  localparam int MCAND_W = VEL_W;
  localparam int MPLR_W  = GRAV_W;
  localparam int PROD_W  = MCAND_W + MPLR_W;
  localparam int MCNT_W  = $clog2(MPLR_W);
  localparam int STEP_W  = VEL_W + DT_W - FRAC_DT;

  // bias averaging
  localparam int BIAS_WINDOW = 100;
  localparam int BCNT_W      = $clog2(BIAS_WINDOW);
  localparam int ACC_W       = CORR_W + BCNT_W;
  localparam int DCNT_W      = $clog2(ACC_W);

  // register file
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_BAND  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DRIFT = 1'd1;
  localparam logic [BAND_W-1:0]    BAND_RST  = 16'd1966;
  localparam logic [DRIFT_W-1:0]   DRIFT_RST = 26'd1048576;

  // stream widths
  localparam int IN_TDATA_W  = ((ACCEL_W + DT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CORR_W + VEL_W + DIST_W + 7) / 8) * 8;

  typedef struct packed {
    logic                      start;
    logic signed [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]         mplr;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/vaiz_smul.sv =====
// ----------------------------------------------------------------------------
// vaiz_smul
// serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module vaiz_smul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vaiz_pkg::mul_req_t req_i,
  output vaiz_pkg::mul_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [vaiz_pkg::MCNT_W-1:0]         cnt_q, cnt_d;
  logic signed [vaiz_pkg::MCAND_W:0]   hi_q, hi_d;
  logic [vaiz_pkg::MPLR_W-1:0]         lo_q, lo_d;
  logic signed [vaiz_pkg::MCAND_W-1:0] mc_q, mc_d;
  logic signed [vaiz_pkg::MCAND_W:0]   addend;
  logic signed [vaiz_pkg::MCAND_W:0]   sum;
  logic                                last;

  always_comb begin
    last   = cnt_q == vaiz_pkg::MCNT_W'(vaiz_pkg::MPLR_W - 1);
    addend = lo_q[0] ? {mc_q[vaiz_pkg::MCAND_W-1], mc_q} : '0;
    sum    = hi_q + addend;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    mc_d   = mc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      lo_d   = req_i.mplr;
      mc_d   = req_i.mcand;
    end else if (busy_q) begin
      // add then shift the whole partial product right by one
      hi_d  = {sum[vaiz_pkg::MCAND_W], sum[vaiz_pkg::MCAND_W:1]};
      lo_d  = {sum[0], lo_q[vaiz_pkg::MPLR_W-1:1]};
      cnt_d = cnt_q + vaiz_pkg::MCNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    mc_q <= mc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q[vaiz_pkg::MCAND_W-1:0], lo_q};

endmodule

// ===== sv/vaiz_sdiv.sv =====
// ----------------------------------------------------------------------------
// vaiz_sdiv
// restoring divider by the bias window length, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vaiz_sdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vaiz_pkg::div_req_t req_i,
  output vaiz_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [vaiz_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic [vaiz_pkg::BCNT_W-1:0]   rem_q, rem_d;
  logic [vaiz_pkg::ACC_W-1:0]    num_q, num_d;
  logic [vaiz_pkg::BCNT_W:0]     trial;
  logic [vaiz_pkg::BCNT_W:0]     diff;
  logic                          ge;
  logic                          last;

  always_comb begin
    last   = cnt_q == vaiz_pkg::DCNT_W'(vaiz_pkg::ACC_W - 1);
    trial  = {rem_q, num_q[vaiz_pkg::ACC_W-1]};
    ge     = trial >= (vaiz_pkg::BCNT_W + 1)'(vaiz_pkg::BIAS_WINDOW);
    diff   = trial - (vaiz_pkg::BCNT_W + 1)'(vaiz_pkg::BIAS_WINDOW);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = req_i.num;
    end else if (busy_q) begin
      // quotient bits enter from the bottom as dividend bits leave the top
      rem_d = ge ? diff[vaiz_pkg::BCNT_W-1:0] : trial[vaiz_pkg::BCNT_W-1:0];
      num_d = {num_q[vaiz_pkg::ACC_W-2:0], ge};
      cnt_d = cnt_q + vaiz_pkg::DCNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

// ===== sv/vaiz_cfg.sv =====
// ----------------------------------------------------------------------------
// vaiz_cfg
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module vaiz_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vaiz_pkg::APB_AW-1:0]   paddr,
  input  logic [vaiz_pkg::APB_DW-1:0]   pwdata,
  output logic [vaiz_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [vaiz_pkg::BAND_W-1:0]   band_o
);

  logic [vaiz_pkg::BAND_W-1:0]    band_q, band_d;
  logic [vaiz_pkg::DRIFT_W-1:0]   drift_q, drift_d;
  logic [vaiz_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign pready = 1'b1;
  assign idx    = paddr[vaiz_pkg::APB_AW-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    band_d  = band_q;
    drift_d = drift_q;
    if (wr) begin
      case (idx)
        vaiz_pkg::REG_BAND:  band_d  = pwdata[vaiz_pkg::BAND_W-1:0];
        vaiz_pkg::REG_DRIFT: drift_d = pwdata[vaiz_pkg::DRIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vaiz_pkg::REG_BAND:  prdata = vaiz_pkg::APB_DW'(band_q);
      vaiz_pkg::REG_DRIFT: prdata = vaiz_pkg::APB_DW'(drift_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q  <= vaiz_pkg::BAND_RST;
      drift_q <= vaiz_pkg::DRIFT_RST;
    end else begin
      band_q  <= band_d;
      drift_q <= drift_d;
    end
  end

  assign band_o = band_q;

endmodule

// ===== sv/vertical_accel_integrator_zupt_core.sv =====
// ----------------------------------------------------------------------------
// vertical_accel_integrator_zupt_core
// vertical acceleration integrator with zero-velocity update and bias averaging
//
//   port group | dir | contents
//   s_axis     | in  | tdata: accel_z, time_step
//   m_axis     | out | tdata: accel_corrected, velocity, distance; tuser: stationary
//   apb        | in  | stationary_band at 0x0, drift_reset_time at 0x4
//
// one sample at a time; the three multiplies share one shift-add unit
// each multiply: a start request, one shift-add per multiplier bit, then a done strobe
// moving sample: error multiply, correction, velocity multiply and add, distance multiply and add, output
// stationary sample: error multiply, bias accumulate, correction, output; a divide when the window closes
// reset clears velocity, distance, bias state and loads register defaults
// a result waits in the output register while the next sample runs; a stall holds it
// ----------------------------------------------------------------------------
module vertical_accel_integrator_zupt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vaiz_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // accel_z, time_step
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [vaiz_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // accel_corrected, velocity, distance
  output logic                               m_axis_tuser,   // stationary
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vaiz_pkg::APB_AW-1:0]        paddr,
  input  logic [vaiz_pkg::APB_DW-1:0]        pwdata,
  output logic [vaiz_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  typedef enum logic [13:0] {
    ST_IDLE       = 14'b00000000000001,
    ST_ERR_START  = 14'b00000000000010,
    ST_ERR_WAIT   = 14'b00000000000100,
    ST_BIAS       = 14'b00000000001000,
    ST_DIV_START  = 14'b00000000010000,
    ST_DIV_WAIT   = 14'b00000000100000,
    ST_CORR       = 14'b00000001000000,
    ST_VEL_START  = 14'b00000010000000,
    ST_VEL_WAIT   = 14'b00000100000000,
    ST_VEL_ADD    = 14'b00001000000000,
    ST_DIST_START = 14'b00010000000000,
    ST_DIST_WAIT  = 14'b00100000000000,
    ST_DIST_ADD   = 14'b01000000000000,
    ST_OUT        = 14'b10000000000000
  } state_e;

  localparam int RNDG_W = vaiz_pkg::PROD_W - vaiz_pkg::FRAC_G + 1;
  localparam int RNDT_W = vaiz_pkg::PROD_W - vaiz_pkg::FRAC_DT + 1;
  localparam logic [vaiz_pkg::ACC_W-1:0] HALF_WIN =
    vaiz_pkg::ACC_W'(vaiz_pkg::BIAS_WINDOW / 2);

  state_e                                state_q, state_d;
  logic                                  m_valid_q, m_valid_d;
  logic [vaiz_pkg::BAND_W-1:0]           band;
  vaiz_pkg::mul_req_t                    mul_req;
  vaiz_pkg::mul_rsp_t                    mul_rsp;
  vaiz_pkg::div_req_t                    div_req;
  vaiz_pkg::div_rsp_t                    div_rsp;

  logic signed [vaiz_pkg::ERRG_W-1:0]    errg_q, errg_d;
  logic [vaiz_pkg::DT_W-1:0]             dt_q, dt_d;
  logic                                  still_q, still_d;
  logic signed [vaiz_pkg::CORR_W-1:0]    errms_q, errms_d;
  logic signed [vaiz_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic [vaiz_pkg::BCNT_W-1:0]           bcnt_q, bcnt_d;
  logic                                  acc_neg_q, acc_neg_d;
  logic signed [vaiz_pkg::CORR_W-1:0]    est_q, est_d;
  logic signed [vaiz_pkg::CORR_W-1:0]    corr_q, corr_d;
  logic signed [vaiz_pkg::STEP_W-1:0]    step_q, step_d;
  logic signed [vaiz_pkg::VEL_W-1:0]     vel_q, vel_d;
  logic signed [vaiz_pkg::DIST_W-1:0]    dist_q, dist_d;
  logic                                  out_still_q, out_still_d;
  logic [vaiz_pkg::CORR_W-1:0]           out_corr_q, out_corr_d;
  logic [vaiz_pkg::VEL_W-1:0]            out_vel_q, out_vel_d;
  logic [vaiz_pkg::DIST_W-1:0]           out_dist_q, out_dist_d;

  logic                                  in_acc;
  logic [vaiz_pkg::ERRG_W-1:0]           mag;
  logic [RNDG_W-1:0]                     rnd_g;
  logic [RNDT_W-1:0]                     rnd_t;
  logic signed [vaiz_pkg::ACC_W-1:0]     acc_sum;
  logic [vaiz_pkg::CORR_W-1:0]           quo_lo;
  logic signed [vaiz_pkg::CORR_W:0]      cdiff;
  logic signed [vaiz_pkg::VEL_W:0]       vsum;
  logic signed [vaiz_pkg::DIST_W:0]      dsum;

  vaiz_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .band_o  (band)
  );

  vaiz_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  vaiz_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mag     = errg_q[vaiz_pkg::ERRG_W-1] ? -errg_q : errg_q;
    rnd_g   = mul_rsp.prod[vaiz_pkg::PROD_W-1:vaiz_pkg::FRAC_G-1] + RNDG_W'(1);
    rnd_t   = mul_rsp.prod[vaiz_pkg::PROD_W-1:vaiz_pkg::FRAC_DT-1] + RNDT_W'(1);
    acc_sum = acc_q + vaiz_pkg::ACC_W'(errms_q);
    quo_lo  = div_rsp.quo[vaiz_pkg::CORR_W-1:0];
    cdiff   = {errms_q[vaiz_pkg::CORR_W-1], errms_q} - {est_q[vaiz_pkg::CORR_W-1], est_q};
    vsum    = {vel_q[vaiz_pkg::VEL_W-1], vel_q} + (vaiz_pkg::VEL_W + 1)'(step_q);
    dsum    = {dist_q[vaiz_pkg::DIST_W-1], dist_q} + (vaiz_pkg::DIST_W + 1)'(step_q);

    state_d     = state_q;
    m_valid_d   = m_valid_q;
    errg_d      = errg_q;
    dt_d        = dt_q;
    still_d     = still_q;
    errms_d     = errms_q;
    acc_d       = acc_q;
    bcnt_d      = bcnt_q;
    acc_neg_d   = acc_neg_q;
    est_d       = est_q;
    corr_d      = corr_q;
    step_d      = step_q;
    vel_d       = vel_q;
    dist_d      = dist_q;
    out_still_d = out_still_q;
    out_corr_d  = out_corr_q;
    out_vel_d   = out_vel_q;
    out_dist_d  = out_dist_q;
    mul_req     = '0;
    div_req     = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          errg_d  = $signed({s_axis_tdata[vaiz_pkg::ACCEL_W-1],
                             s_axis_tdata[vaiz_pkg::ACCEL_W-1:0]}) - vaiz_pkg::ONE_G_Q16;
          dt_d    = s_axis_tdata[vaiz_pkg::ACCEL_W +: vaiz_pkg::DT_W];
          state_d = ST_ERR_START;
        end
      end
      ST_ERR_START: begin
        mul_req.start = 1'b1;
        mul_req.mcand = vaiz_pkg::MCAND_W'(errg_q);
        mul_req.mplr  = vaiz_pkg::GRAV_Q16;
        still_d       = mag < vaiz_pkg::ERRG_W'(band);
        state_d       = ST_ERR_WAIT;
      end
      ST_ERR_WAIT: begin
        if (mul_rsp.done) begin
          errms_d = rnd_g[vaiz_pkg::CORR_W:1];
          state_d = still_q ? ST_BIAS : ST_CORR;
        end
      end
      ST_BIAS: begin
        acc_d = acc_sum;
        if (bcnt_q == vaiz_pkg::BCNT_W'(vaiz_pkg::BIAS_WINDOW - 1)) begin
          state_d = ST_DIV_START;
        end else begin
          bcnt_d  = bcnt_q + vaiz_pkg::BCNT_W'(1);
          state_d = ST_CORR;
        end
      end
      ST_DIV_START: begin
        // rounding half away from zero on the magnitude
        div_req.start = 1'b1;
        div_req.num   = acc_q[vaiz_pkg::ACC_W-1] ? HALF_WIN - acc_q : acc_q + HALF_WIN;
        acc_neg_d     = acc_q[vaiz_pkg::ACC_W-1];
        acc_d         = '0;
        bcnt_d        = '0;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          est_d   = acc_neg_q ? -quo_lo : quo_lo;
          state_d = ST_CORR;
        end
      end
      ST_CORR: begin
        if (cdiff[vaiz_pkg::CORR_W] != cdiff[vaiz_pkg::CORR_W-1]) begin
          corr_d = cdiff[vaiz_pkg::CORR_W] ? {1'b1, {(vaiz_pkg::CORR_W-1){1'b0}}}
                                           : {1'b0, {(vaiz_pkg::CORR_W-1){1'b1}}};
        end else begin
          corr_d = cdiff[vaiz_pkg::CORR_W-1:0];
        end
        if (still_q) begin
          vel_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_VEL_START;
        end
      end
      ST_VEL_START: begin
        mul_req.start = 1'b1;
        mul_req.mcand = vaiz_pkg::MCAND_W'(corr_q);
        mul_req.mplr  = vaiz_pkg::MPLR_W'(dt_q);
        state_d       = ST_VEL_WAIT;
      end
      ST_VEL_WAIT: begin
        if (mul_rsp.done) begin
          step_d  = rnd_t[vaiz_pkg::STEP_W:1];
          state_d = ST_VEL_ADD;
        end
      end
      ST_VEL_ADD: begin
        if (vsum[vaiz_pkg::VEL_W] != vsum[vaiz_pkg::VEL_W-1]) begin
          vel_d = vsum[vaiz_pkg::VEL_W] ? {1'b1, {(vaiz_pkg::VEL_W-1){1'b0}}}
                                        : {1'b0, {(vaiz_pkg::VEL_W-1){1'b1}}};
        end else begin
          vel_d = vsum[vaiz_pkg::VEL_W-1:0];
        end
        state_d = ST_DIST_START;
      end
      ST_DIST_START: begin
        mul_req.start = 1'b1;
        mul_req.mcand = vel_q;
        mul_req.mplr  = vaiz_pkg::MPLR_W'(dt_q);
        state_d       = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (mul_rsp.done) begin
          step_d  = rnd_t[vaiz_pkg::STEP_W:1];
          state_d = ST_DIST_ADD;
        end
      end
      ST_DIST_ADD: begin
        if (dsum[vaiz_pkg::DIST_W] != dsum[vaiz_pkg::DIST_W-1]) begin
          dist_d = dsum[vaiz_pkg::DIST_W] ? {1'b1, {(vaiz_pkg::DIST_W-1){1'b0}}}
                                          : {1'b0, {(vaiz_pkg::DIST_W-1){1'b1}}};
        end else begin
          dist_d = dsum[vaiz_pkg::DIST_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_still_d = still_q;
          out_corr_d  = corr_q;
          out_vel_d   = vel_q;
          out_dist_d  = dist_q;
          m_valid_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      acc_q     <= '0;
      bcnt_q    <= '0;
      est_q     <= '0;
      vel_q     <= '0;
      dist_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      acc_q     <= acc_d;
      bcnt_q    <= bcnt_d;
      est_q     <= est_d;
      vel_q     <= vel_d;
      dist_q    <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    errg_q      <= errg_d;
    dt_q        <= dt_d;
    still_q     <= still_d;
    errms_q     <= errms_d;
    acc_neg_q   <= acc_neg_d;
    corr_q      <= corr_d;
    step_q      <= step_d;
    out_still_q <= out_still_d;
    out_corr_q  <= out_corr_d;
    out_vel_q   <= out_vel_d;
    out_dist_q  <= out_dist_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_still_q;
  assign m_axis_tdata  = vaiz_pkg::OUT_TDATA_W'({out_dist_q, out_vel_q, out_corr_q});

endmodule

// ===== sv/vaiz_checker.sv =====
// ----------------------------------------------------------------------------
// vaiz_checker
// port-level assertions for the vertical accel integrator, bound to the top
// ----------------------------------------------------------------------------
`include "vertical_accel_integrator_zupt_core_assert.svh"

module vaiz_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [vaiz_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tuser
);

  logic [vaiz_pkg::VEL_W-1:0]       out_vel;
  logic [vaiz_pkg::OUT_TDATA_W:0]   out_word;
  logic                             out_stall;
  logic                             out_still;
  logic                             in_acc;

  assign out_vel   = m_axis_tdata[vaiz_pkg::CORR_W +: vaiz_pkg::VEL_W];
  assign out_word  = {m_axis_tuser, m_axis_tdata};
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_still = m_axis_tvalid && m_axis_tuser;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // result stays offered until taken
  `VAIZ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result dropped")

  // a stalled result keeps its payload
  `VAIZ_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_word), "stalled result changed")

  // a stationary sample always reports zero velocity
  `VAIZ_ASSERT_IMPLY(a_still_zero_vel, out_still, out_vel == '0, "velocity not cleared")

  // one sample in flight: no transaction in the cycle after one is taken
  `VAIZ_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "input taken while busy")

endmodule

bind vertical_accel_integrator_zupt_core vaiz_checker u_vaiz_checker (.*);
